FILE: rtl/ges_pkg.sv
// ----------------------------------------------------------------------------
// ges_pkg
// shared constants, types and helpers of the glyph extent scanner
// ----------------------------------------------------------------------------
package ges_pkg;

  localparam int MAX_SHEET_SIDE = 1024;
  localparam int GRID           = 16;
  localparam int GRID_W         = $clog2(GRID);
  localparam int COORD_W        = $clog2(MAX_SHEET_SIDE);
  localparam int CFG_W          = COORD_W + 1;
  localparam int OFS_W          = COORD_W - GRID_W;
  localparam int SPAN_W         = OFS_W + 1;
  localparam int PIX_W          = 32;
  localparam int CHAR_W         = 2 * GRID_W;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(65);
  localparam logic [CFG_W-1:0]  SIDE_MIN   = CFG_W'(GRID);
  localparam logic [CFG_W-1:0]  SIDE_MAX   = CFG_W'(MAX_SHEET_SIDE);
  localparam logic [CFG_W-1:0]  SIDE_RESET = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHEET_WIDTH  = 1'b0,
    CFG_SHEET_HEIGHT = 1'b1
  } cfg_idx_t;

  // sheet geometry derived from the size registers
  typedef struct packed {
    logic [SPAN_W-1:0]  cw;
    logic [SPAN_W-1:0]  ch;
    logic [OFS_W-1:0]   cw_max;
    logic [OFS_W-1:0]   ch_max;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
  } geom_t;

  // one pixel with its position already resolved into cell terms
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [OFS_W-1:0]  pc;
    logic [GRID_W-1:0] col;
    logic [OFS_W-1:0]  pr;
    logic [GRID_W-1:0] row;
    logic              first;
    logic              in_grid;
    logic              is_a;
    logic              row_end;
    logic              sheet_end;
  } pix_t;

  typedef struct packed {
    logic [OFS_W-1:0] left;
    logic [OFS_W-1:0] right;
    logic             inked;
  } cell_t;

  localparam cell_t CELL_CLEAR = '{left: '1, right: '0, inked: 1'b0};

  // burst handed from the accumulator to the emitter
  typedef struct packed {
    logic                   glyph;
    logic                   summary;
    logic [GRID_W-1:0]      row;
    cell_t [GRID-1:0]       cells;
    logic [SPAN_W-1:0]      top;
    logic [SPAN_W-1:0]      step;
  } load_t;

  typedef struct packed {
    logic               is_summary;
    logic [CHAR_W-1:0]  char_code;
    logic [COORD_W-1:0] glyph_x;
    logic [SPAN_W-1:0]  glyph_width;
    logic [SPAN_W-1:0]  top_trim;
    logic [SPAN_W-1:0]  line_step;
    logic [OFS_W-1:0]   space_width;
    logic               last;
  } rec_t;

  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < SIDE_MIN) r = SIDE_MIN;
    else if (v > SIDE_MAX) r = SIDE_MAX;
    return r;
  endfunction

endpackage

FILE: rtl/ges_coord.sv
// ----------------------------------------------------------------------------
// ges_coord
// raster position tracking and input register
// ----------------------------------------------------------------------------
module ges_coord (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ges_pkg::geom_t              geom,
  input  logic                        restart,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ges_pkg::PIX_W-1:0]   in_pixel_value,
  input  logic                        hold,
  output logic                        s1_valid,
  output ges_pkg::pix_t               s1
);
  import ges_pkg::*;

  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [OFS_W-1:0]   pc_r, pc_nxt, pr_r, pr_nxt;
  logic [GRID_W:0]    cc_r, cc_nxt, rr_r, rr_nxt;
  logic               s1_valid_r;
  pix_t               s1_r, pix;
  logic               accept, x_last, y_last;

  // cell column and row counters saturate at GRID: outside the grid
  always_comb begin
    in_stall = hold;
    accept   = in_valid && !in_stall;
    x_last   = (x_r == geom.x_max);
    y_last   = (y_r == geom.y_max);

    pix.pixel     = in_pixel_value;
    pix.pc        = pc_r;
    pix.col       = cc_r[GRID_W-1:0];
    pix.pr        = pr_r;
    pix.row       = rr_r[GRID_W-1:0];
    pix.first     = (x_r == '0) && (y_r == '0);
    pix.in_grid   = !cc_r[GRID_W] && !rr_r[GRID_W];
    pix.is_a      = pix.in_grid && ({rr_r[GRID_W-1:0], cc_r[GRID_W-1:0]} == CHAR_A);
    pix.row_end   = x_last && !rr_r[GRID_W] && (pr_r == geom.ch_max);
    pix.sheet_end = x_last && y_last;

    x_nxt  = x_r + 1'b1;
    pc_nxt = pc_r + 1'b1;
    cc_nxt = cc_r;
    y_nxt  = y_r;
    pr_nxt = pr_r;
    rr_nxt = rr_r;
    if (pc_r == geom.cw_max) begin
      pc_nxt = '0;
      if (!cc_r[GRID_W]) cc_nxt = cc_r + 1'b1;
    end
    if (x_last) begin
      x_nxt  = '0;
      pc_nxt = '0;
      cc_nxt = '0;
      if (y_last) begin
        y_nxt  = '0;
        pr_nxt = '0;
        rr_nxt = '0;
      end else begin
        y_nxt  = y_r + 1'b1;
        pr_nxt = pr_r + 1'b1;
        if (pr_r == geom.ch_max) begin
          pr_nxt = '0;
          if (!rr_r[GRID_W]) rr_nxt = rr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r        <= '0;
      y_r        <= '0;
      pc_r       <= '0;
      pr_r       <= '0;
      cc_r       <= '0;
      rr_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (restart) begin
        x_r  <= '0;
        y_r  <= '0;
        pc_r <= '0;
        pr_r <= '0;
        cc_r <= '0;
        rr_r <= '0;
      end else if (accept) begin
        x_r  <= x_nxt;
        y_r  <= y_nxt;
        pc_r <= pc_nxt;
        pr_r <= pr_nxt;
        cc_r <= cc_nxt;
        rr_r <= rr_nxt;
      end
      if (!hold) s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && accept) s1_r <= pix;
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

FILE: rtl/ges_accum.sv
// ----------------------------------------------------------------------------
// ges_accum
// ink detection and per-cell extent accumulation
// ----------------------------------------------------------------------------
module ges_accum (
  input  logic            clk,
  input  logic            rst_n,
  input  ges_pkg::geom_t  geom,
  input  logic            restart,
  input  logic            s1_valid,
  input  ges_pkg::pix_t   s1,
  input  logic            emit_free,
  output logic            hold,
  output logic            load_valid,
  output ges_pkg::load_t  load
);
  import ges_pkg::*;

  logic [PIX_W-1:0]  bg_r, bg_nxt;
  logic [SPAN_W-1:0] top_r, top_nxt, abot_r, abot_nxt, pr_ext;
  cell_t [GRID-1:0]  cells_r, cells_nxt, cells_upd;
  cell_t             cur, upd;
  logic              fire, ink, clear;

  always_comb begin
    hold   = s1_valid && (s1.row_end || s1.sheet_end) && !emit_free;
    fire   = s1_valid && !hold;
    cur    = cells_r[s1.col];
    pr_ext = SPAN_W'(s1.pr);
    // the first pixel sets the background, so it never counts as ink
    ink    = fire && s1.in_grid && !s1.first && (s1.pixel != bg_r);

    upd.left  = (!cur.inked || (s1.pc < cur.left))  ? s1.pc : cur.left;
    upd.right = (!cur.inked || (s1.pc > cur.right)) ? s1.pc : cur.right;
    upd.inked = 1'b1;

    cells_upd = cells_r;
    if (ink) cells_upd[s1.col] = upd;

    clear = restart || (fire && (s1.first || s1.row_end));
    for (int i = 0; i < GRID; i++) begin
      cells_nxt[i] = clear ? CELL_CLEAR : cells_upd[i];
    end

    bg_nxt   = (fire && s1.first) ? s1.pixel : bg_r;
    top_nxt  = top_r;
    abot_nxt = abot_r;
    if (fire && s1.first) begin
      top_nxt  = geom.ch;
      abot_nxt = geom.ch;
    end else if (ink) begin
      if (pr_ext < top_r) top_nxt = pr_ext;
      if (s1.is_a && ((abot_r == geom.ch) || (pr_ext > abot_r))) abot_nxt = pr_ext;
    end

    load_valid   = fire && (s1.row_end || s1.sheet_end);
    load.glyph   = s1.row_end;
    load.summary = s1.sheet_end;
    load.row     = s1.row;
    load.cells   = cells_upd;
    load.top     = top_nxt;
    load.step    = (abot_nxt >= top_nxt) ? (abot_nxt - top_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r   <= '0;
      top_r  <= '0;
      abot_r <= '0;
      for (int i = 0; i < GRID; i++) cells_r[i] <= CELL_CLEAR;
    end else begin
      bg_r    <= bg_nxt;
      top_r   <= top_nxt;
      abot_r  <= abot_nxt;
      cells_r <= cells_nxt;
    end
  end

endmodule

FILE: rtl/ges_emit.sv
// ----------------------------------------------------------------------------
// ges_emit
// glyph record burst emitter with output register
// ----------------------------------------------------------------------------
module ges_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  ges_pkg::geom_t  geom,
  input  logic            load_valid,
  input  ges_pkg::load_t  load,
  output logic            emit_free,
  output logic            out_valid,
  input  logic            out_stall,
  output ges_pkg::rec_t   rec
);
  import ges_pkg::*;

  cell_t [GRID-1:0]   sh_r, sh_nxt;
  logic [GRID_W-1:0]  row_r, row_nxt, idx_r, idx_nxt;
  logic [COORD_W-1:0] start_r, start_nxt;
  logic [SPAN_W-1:0]  tt_r, tt_nxt, st_r, st_nxt;
  logic               glyph_busy_r, glyph_busy_nxt, sum_busy_r, sum_busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  rec_t               rec_r, rec_nxt, grec, srec;
  cell_t              cur;
  logic               slot, gl_last, finishing;

  always_comb begin
    slot      = !out_valid_r || !out_stall;
    gl_last   = (idx_r == GRID_W'(GRID - 1));
    finishing = slot && ((glyph_busy_r && gl_last && !sum_busy_r) ||
                         (!glyph_busy_r && sum_busy_r));
    emit_free = !(glyph_busy_r || sum_busy_r) || finishing;
    cur       = sh_r[idx_r];

    grec.is_summary  = 1'b0;
    grec.char_code   = {row_r, idx_r};
    grec.glyph_x     = cur.inked ? (start_r + COORD_W'(cur.left)) : start_r;
    grec.glyph_width = cur.inked ?
                       (SPAN_W'(cur.right) - SPAN_W'(cur.left) + 1'b1) : geom.cw;
    grec.top_trim    = '0;
    grec.line_step   = '0;
    grec.space_width = '0;
    grec.last        = gl_last && !sum_busy_r;

    srec.is_summary  = 1'b1;
    srec.char_code   = '0;
    srec.glyph_x     = '0;
    srec.glyph_width = '0;
    srec.top_trim    = tt_r;
    srec.line_step   = st_r;
    srec.space_width = geom.cw[SPAN_W-1:1];
    srec.last        = 1'b1;

    sh_nxt         = sh_r;
    row_nxt        = row_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    tt_nxt         = tt_r;
    st_nxt         = st_r;
    glyph_busy_nxt = glyph_busy_r;
    sum_busy_nxt   = sum_busy_r;
    out_valid_nxt  = out_valid_r;
    rec_nxt        = rec_r;

    if (slot) begin
      if (glyph_busy_r) begin
        rec_nxt       = grec;
        out_valid_nxt = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        start_nxt     = start_r + COORD_W'(geom.cw);
        if (gl_last) glyph_busy_nxt = 1'b0;
      end else if (sum_busy_r) begin
        rec_nxt       = srec;
        out_valid_nxt = 1'b1;
        sum_busy_nxt  = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    // a new burst may land in the cycle the previous one drains
    if (load_valid) begin
      sh_nxt         = load.cells;
      row_nxt        = load.row;
      tt_nxt         = load.top;
      st_nxt         = load.step;
      glyph_busy_nxt = load.glyph;
      sum_busy_nxt   = load.summary;
      idx_nxt        = '0;
      start_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_busy_r <= 1'b0;
      sum_busy_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      glyph_busy_r <= glyph_busy_nxt;
      sum_busy_r   <= sum_busy_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    row_r   <= row_nxt;
    start_r <= start_nxt;
    tt_r    <= tt_nxt;
    st_r    <= st_nxt;
    rec_r   <= rec_nxt;
  end

  assign out_valid = out_valid_r;
  assign rec       = rec_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_valid |-> emit_free)
    else $error("burst loaded while the emitter is still busy");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> glyph_busy_r)
    else $error("glyph index moved outside a burst");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_busy_r && !glyph_busy_r && slot) |=> (rec_r.is_summary && rec_r.last && out_valid_r))
    else $error("summary record not issued as the last of its run");
`endif

endmodule

FILE: rtl/glyph_extent_scanner_unit.sv
// ----------------------------------------------------------------------------
// glyph_extent_scanner_unit
// bitmap font sheet scanner giving glyph boxes and sheet metrics
// ----------------------------------------------------------------------------
// usage
//   in_*   : one 32-bit sheet pixel per transaction, raster order; the first
//            pixel of a sheet is taken as the background colour
//   out_*  : glyph records (16 per cell row, after its last pixel) and one
//            summary record after the last pixel of the sheet; last_of_run
//            marks the final record caused by a pixel
//   cfg_*  : sheet width / height registers, always ready; a write restarts
//            the sheet and must only be issued while the block is idle
// path       : first record of a pixel passes the input register, the snapshot
//              bank and then the output register
// throughput : one pixel per clock; the emitter drives one record per clock
//              while out_stall is low, from a snapshot bank, so a cell-row or
//              sheet end only holds the input when the previous burst has not
//              yet drained (17 records when the sheet ends on a cell-row end)
// stall      : out_stall freezes the output register; the emitter and then
//              the input stall back up behind it with nothing lost
// reset      : sizes return to 256 x 256, counters to the sheet origin, all
//              cell extents cleared; no clearing pass is needed
// ----------------------------------------------------------------------------
module glyph_extent_scanner_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ges_pkg::PIX_W-1:0]      in_pixel_value,
  // record output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_summary,
  output logic [ges_pkg::CHAR_W-1:0]     out_char_code,
  output logic [ges_pkg::COORD_W-1:0]    out_glyph_x,
  output logic [ges_pkg::SPAN_W-1:0]     out_glyph_width,
  output logic [ges_pkg::SPAN_W-1:0]     out_top_trim,
  output logic [ges_pkg::SPAN_W-1:0]     out_line_step,
  output logic [ges_pkg::OFS_W-1:0]      out_space_width,
  output logic                           out_last_of_run,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ges_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ges_pkg::CFG_W-1:0]      cfg_data
);
  import ges_pkg::*;

  logic [CFG_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [CFG_W-1:0] w_cl, h_cl;
  logic             cfg_wr, restart;
  geom_t            geom;
  logic             s1_valid, hold, emit_free, load_valid;
  pix_t             s1;
  load_t            load;
  rec_t             rec;

  // register file: every write restarts the sheet scan
  always_comb begin
    cfg_ready  = 1'b1;
    cfg_wr     = cfg_valid && cfg_ready;
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SHEET_WIDTH: begin
          width_nxt = cfg_data;
          restart   = 1'b1;
        end
        CFG_SHEET_HEIGHT: begin
          height_nxt = cfg_data;
          restart    = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_RESET;
      height_r <= SIDE_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // sizes saturated into range; cell sides are the sides over the grid
  always_comb begin
    w_cl        = clamp_side(width_r);
    h_cl        = clamp_side(height_r);
    geom.cw     = w_cl[CFG_W-1:GRID_W];
    geom.ch     = h_cl[CFG_W-1:GRID_W];
    geom.cw_max = OFS_W'(geom.cw - 1'b1);
    geom.ch_max = OFS_W'(geom.ch - 1'b1);
    geom.x_max  = COORD_W'(w_cl - 1'b1);
    geom.y_max  = COORD_W'(h_cl - 1'b1);
  end

  // position tracking and input register
  ges_coord u_coord (
    .clk            (clk),
    .rst_n          (rst_n),
    .geom           (geom),
    .restart        (restart),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .hold           (hold),
    .s1_valid       (s1_valid),
    .s1             (s1)
  );

  // ink test and extent update, hands a snapshot at each cell-row end and sheet end
  ges_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .restart    (restart),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .emit_free  (emit_free),
    .hold       (hold),
    .load_valid (load_valid),
    .load       (load)
  );

  // record burst out of the snapshot bank
  ges_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .load_valid (load_valid),
    .load       (load),
    .emit_free  (emit_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rec        (rec)
  );

  assign out_is_summary  = rec.is_summary;
  assign out_char_code   = rec.char_code;
  assign out_glyph_x     = rec.glyph_x;
  assign out_glyph_width = rec.glyph_width;
  assign out_top_trim    = rec.top_trim;
  assign out_line_step   = rec.line_step;
  assign out_space_width = rec.space_width;
  assign out_last_of_run = rec.last;

endmodule
